>>> rtl/core/rrtq_pkg.sv
// rrtq_pkg: shared types and constants of the round-robin task queue unit
// no dependencies; imported by rrtq_ram users, rrtq_update and the top level
`default_nettype none
package rrtq_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TASK_W    = $clog2(MAX_TASKS);
  localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
  localparam int SLICE_W   = 16;
  localparam int KIND_W    = 3;

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(100);

  // operation codes
  localparam logic [KIND_W-1:0] K_ENQ  = 3'd0;
  localparam logic [KIND_W-1:0] K_DEQ  = 3'd1;
  localparam logic [KIND_W-1:0] K_YLD  = 3'd2;
  localparam logic [KIND_W-1:0] K_TICK = 3'd3;
  localparam logic [KIND_W-1:0] K_PICK = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic              at_head;
    logic              task_in_class;
  } rrtq_in_t;

  typedef struct packed {
    logic [TASK_W-1:0]  picked_task;
    logic               queue_empty;
    logic               resched;
    logic [COUNT_W-1:0] queue_count;
    logic               error;
  } rrtq_out_t;

  // one link memory write
  typedef struct packed {
    logic              en;
    logic [TASK_W-1:0] addr;
    logic [TASK_W-1:0] data;
  } rrtq_lwr_t;

  // queue state and memory read data seen by the update logic
  typedef struct packed {
    logic [TASK_W-1:0]  head;
    logic [TASK_W-1:0]  tail;
    logic [COUNT_W-1:0] count;
    logic               queued;
    logic [TASK_W-1:0]  next_rd;
    logic [TASK_W-1:0]  prev_rd;
    logic [SLICE_W-1:0] slice_rd;
    logic [SLICE_W-1:0] slice_len;
  } rrtq_ctx_t;

  // everything the update logic decides for one word
  typedef struct packed {
    logic [TASK_W-1:0]  head;
    logic [TASK_W-1:0]  tail;
    logic [COUNT_W-1:0] count;
    logic               q_we;
    logic               q_val;
    rrtq_lwr_t          next_a;
    rrtq_lwr_t          prev_a;
    rrtq_lwr_t          next_b;
    rrtq_lwr_t          prev_b;
    logic               slice_we;
    logic [SLICE_W-1:0] slice_data;
    rrtq_out_t          res;
  } rrtq_upd_t;

endpackage
`default_nettype wire

>>> rtl/core/rrtq_ram.sv
// rrtq_ram: generic single write port, single read port synchronous ram
// read data registered; no dependencies
`default_nettype none
module rrtq_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rrtq_update.sv
// rrtq_update: per-word list surgery, slice countdown and status for the queue
// depends on rrtq_pkg; purely combinational, driven by the top level sequencer
`default_nettype none
module rrtq_update (
  input  wire rrtq_pkg::rrtq_in_t  item,
  input  wire rrtq_pkg::rrtq_ctx_t ctx,
  output rrtq_pkg::rrtq_upd_t      upd
);
  import rrtq_pkg::*;

  logic [TASK_W-1:0]  t;
  logic [SLICE_W-1:0] dec;
  logic               do_move;
  logic               many;

  always_comb begin
    t       = item.task_id;
    dec     = ctx.slice_rd - SLICE_W'(1);
    do_move = 1'b0;
    many    = ctx.count >= COUNT_W'(2);

    upd            = '0;
    upd.head       = ctx.head;
    upd.tail       = ctx.tail;
    upd.count      = ctx.count;
    upd.slice_data = dec;

    case (item.kind)
      K_ENQ: begin
        if (ctx.queued) begin
          upd.res.error = 1'b1;
        end else begin
          upd.q_we  = 1'b1;
          upd.q_val = 1'b1;
          upd.count = ctx.count + COUNT_W'(1);
          if (ctx.count == '0) begin
            upd.head = t;
            upd.tail = t;
          end else if (item.at_head) begin
            upd.prev_a = '{en: 1'b1, addr: ctx.head, data: t};
            upd.next_a = '{en: 1'b1, addr: t, data: ctx.head};
            upd.head   = t;
          end else begin
            upd.next_a = '{en: 1'b1, addr: ctx.tail, data: t};
            upd.prev_a = '{en: 1'b1, addr: t, data: ctx.tail};
            upd.tail   = t;
          end
        end
      end
      K_DEQ: begin
        if (!ctx.queued) begin
          upd.res.error = 1'b1;
        end else begin
          upd.q_we  = 1'b1;
          upd.q_val = 1'b0;
          upd.count = ctx.count - COUNT_W'(1);
          if (!many) begin
            upd.head = '0;
            upd.tail = '0;
          end else begin
            if (t == ctx.head) begin
              upd.head = ctx.next_rd;
            end else begin
              upd.next_a = '{en: 1'b1, addr: ctx.prev_rd, data: ctx.next_rd};
            end
            if (t == ctx.tail) begin
              upd.tail = ctx.prev_rd;
            end else begin
              upd.prev_a = '{en: 1'b1, addr: ctx.next_rd, data: ctx.prev_rd};
            end
          end
        end
      end
      K_YLD: begin
        do_move = ctx.queued;
      end
      K_TICK: begin
        if (item.task_in_class) begin
          upd.slice_we = 1'b1;
          if (dec == '0) begin
            upd.slice_data = ctx.slice_len;
            if (ctx.queued && many) begin
              upd.res.resched = 1'b1;
              do_move         = 1'b1;
            end
          end
        end
      end
      K_PICK: begin
        if (ctx.count != '0) begin
          upd.res.picked_task = ctx.head;
        end
      end
      default: begin
      end
    endcase

    // unlink, then append at the tail; the tail write lands second
    if (do_move && many && t != ctx.tail) begin
      if (t == ctx.head) begin
        upd.head = ctx.next_rd;
      end else begin
        upd.next_a = '{en: 1'b1, addr: ctx.prev_rd, data: ctx.next_rd};
      end
      upd.prev_a = '{en: 1'b1, addr: ctx.next_rd, data: ctx.prev_rd};
      upd.next_b = '{en: 1'b1, addr: ctx.tail, data: t};
      upd.prev_b = '{en: 1'b1, addr: t, data: ctx.tail};
      upd.tail   = t;
    end

    upd.res.queue_count = upd.count;
    upd.res.queue_empty = (upd.count == '0);
  end

endmodule
`default_nettype wire

>>> rtl/core/round_robin_task_queue_unit.sv
// round_robin_task_queue_unit: top level, sequencer, queue registers and memories
// depends on rrtq_pkg, rrtq_ram and rrtq_update
`default_nettype none
// Usage:
//  An operation word on in_item is taken at a clock edge with start high and
//  busy low. Kinds: enqueue (head or tail), dequeue, yield, tick, pick.
//  Exactly one result word per operation appears on out_item with out_valid
//  high for one cycle; the receiver cannot hold it off.
//  Timing: when the word is taken, the link and slice memories register the
//  task's entries; in the exec state all updates are decided and the first
//  link writes land; out_valid is high in the write-back state, at whose end
//  the second pair of link writes (append at the tail) lands. busy is high
//  in the exec and write-back states, so a new word is taken only once the
//  last one is through, as each link memory has a single write port.
//  The slice length register is written over cfg_valid/cfg_data; cfg_ready is
//  always high. The user must make writes only while the unit is idle (not enforced).
//  Reset (rst_n low, synchronous) empties the queue, sets the slice length to
//  100 and marks every slice counter as full; no memory clearing pass runs,
//  so the unit is ready in the first cycle after reset.
module round_robin_task_queue_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rrtq_pkg::rrtq_in_t            in_item,
  output logic                               out_valid,
  output rrtq_pkg::rrtq_out_t                out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rrtq_pkg::SLICE_W-1:0]  cfg_data
);
  import rrtq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WB   = 2'd2;

  logic [1:0]           state_r, state_nxt;
  rrtq_in_t             item_r;
  logic [TASK_W-1:0]    head_r, head_nxt;
  logic [TASK_W-1:0]    tail_r, tail_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [MAX_TASKS-1:0] queued_r, queued_nxt;
  logic [MAX_TASKS-1:0] slice_vld_r, slice_vld_nxt;
  logic [SLICE_W-1:0]   slice_len_r;
  rrtq_lwr_t            next_b_r, prev_b_r;
  logic                 out_valid_r;
  rrtq_out_t            out_r;

  logic                 accept;
  logic                 exec;
  logic [TASK_W-1:0]    next_rd, prev_rd;
  logic [SLICE_W-1:0]   slice_rd;
  rrtq_lwr_t            next_wr, prev_wr;
  rrtq_ctx_t            ctx;
  rrtq_upd_t            upd;

  assign accept    = start && !busy;
  assign exec      = (state_r == S_EXEC);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // first write pair in exec, deferred tail append in the write-back state
  assign next_wr = exec ? upd.next_a : next_b_r;
  assign prev_wr = exec ? upd.prev_a : prev_b_r;

  rrtq_ram #(.WIDTH(TASK_W), .ADDR_W(TASK_W)) u_next_ram (
    .clk   (clk),
    .we    (next_wr.en && (exec || state_r == S_WB)),
    .waddr (next_wr.addr),
    .wdata (next_wr.data),
    .re    (accept),
    .raddr (in_item.task_id),
    .rdata (next_rd)
  );

  rrtq_ram #(.WIDTH(TASK_W), .ADDR_W(TASK_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_wr.en && (exec || state_r == S_WB)),
    .waddr (prev_wr.addr),
    .wdata (prev_wr.data),
    .re    (accept),
    .raddr (in_item.task_id),
    .rdata (prev_rd)
  );

  rrtq_ram #(.WIDTH(SLICE_W), .ADDR_W(TASK_W)) u_slice_ram (
    .clk   (clk),
    .we    (exec && upd.slice_we),
    .waddr (item_r.task_id),
    .wdata (upd.slice_data),
    .re    (accept),
    .raddr (in_item.task_id),
    .rdata (slice_rd)
  );

  always_comb begin
    ctx.head      = head_r;
    ctx.tail      = tail_r;
    ctx.count     = count_r;
    ctx.queued    = queued_r[item_r.task_id];
    ctx.next_rd   = next_rd;
    ctx.prev_rd   = prev_rd;
    // counters never written still hold the full reset slice
    ctx.slice_rd  = slice_vld_r[item_r.task_id] ? slice_rd : SLICE_RESET;
    ctx.slice_len = slice_len_r;
  end

  rrtq_update u_update (
    .item (item_r),
    .ctx  (ctx),
    .upd  (upd)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    queued_nxt    = queued_r;
    slice_vld_nxt = slice_vld_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_WB;
        head_nxt  = upd.head;
        tail_nxt  = upd.tail;
        count_nxt = upd.count;
        if (upd.q_we) begin
          queued_nxt[item_r.task_id] = upd.q_val;
        end
        if (upd.slice_we) begin
          slice_vld_nxt[item_r.task_id] = 1'b1;
        end
      end
      S_WB: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      queued_r    <= '0;
      slice_vld_r <= '0;
      slice_len_r <= SLICE_RESET;
      next_b_r    <= '0;
      prev_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      queued_r    <= queued_nxt;
      slice_vld_r <= slice_vld_nxt;
      out_valid_r <= exec;
      if (cfg_valid && cfg_ready) begin
        slice_len_r <= cfg_data;
      end
      if (exec) begin
        next_b_r <= upd.next_b;
        prev_b_r <= upd.prev_b;
      end else begin
        next_b_r <= '0;
        prev_b_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (exec) begin
      out_r <= upd.res;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    $countones(queued_r) == 32'(count_r))
    else $error("queued flags disagree with task count");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0 && tail_r == '0)
    else $error("empty queue with nonzero head or tail");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("result word missing two cycles after start");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> busy && !$past(out_valid_r))
    else $error("result strobe outside the write-back cycle");

endmodule
`default_nettype wire

>>> bench/round_robin_task_queue_unit_test.sv
// self-checking bench for round_robin_task_queue_unit: directed corner cases, then random traffic
// over several slice lengths; depends on rrtq_pkg and the round_robin_task_queue_unit rtl
`timescale 1ns / 1ps

module round_robin_task_queue_unit_test;
  import rrtq_pkg::*;

  // mirror of the run queue: predicts one result word per accepted operation word
  class run_queue_scoreboard;
    int                 nxt [MAX_TASKS];
    int                 prv [MAX_TASKS];
    bit                 queued [MAX_TASKS];
    logic [SLICE_W-1:0] left [MAX_TASKS];
    int                 head;
    int                 tail;
    int                 count;
    logic [SLICE_W-1:0] slice_len;
    rrtq_out_t          expected_words[$];
    int                 errors;
    int                 ops_seen;
    int                 resched_seen;
    int                 err_flags_seen;
    int                 peak_count;

    function new();
      slice_len = SLICE_RESET;
      for (int i = 0; i < MAX_TASKS; i++) begin
        nxt[i] = 0;
        prv[i] = 0;
        queued[i] = 0;
        left[i] = SLICE_RESET;
      end
      head = 0;
      tail = 0;
      count = 0;
      errors = 0;
      ops_seen = 0;
      resched_seen = 0;
      err_flags_seen = 0;
      peak_count = 0;
    endfunction

    function void link_tail(int t);
      if (count == 0) begin
        head = t;
        tail = t;
      end else begin
        nxt[tail] = t;
        prv[t] = tail;
        tail = t;
      end
      queued[t] = 1;
      count++;
    endfunction

    function void link_head(int t);
      if (count == 0) begin
        head = t;
        tail = t;
      end else begin
        prv[head] = t;
        nxt[t] = head;
        head = t;
      end
      queued[t] = 1;
      count++;
    endfunction

    function void unlink(int t);
      int p;
      int n;
      p = prv[t];
      n = nxt[t];
      if (count <= 1) begin
        head = 0;
        tail = 0;
      end else begin
        if (t == head) head = n;
        else nxt[p] = n;
        if (t == tail) tail = p;
        else prv[n] = p;
      end
      queued[t] = 0;
      if (count > 0) count--;
    endfunction

    function void rotate_to_tail(int t);
      if (count < 2 || t == tail) return;
      unlink(t);
      link_tail(t);
    endfunction

    function void note_op(rrtq_in_t w);
      rrtq_out_t r;
      int t;
      r = '0;
      t = int'(w.task_id);
      if (t < MAX_TASKS) begin
        case (w.kind)
          K_ENQ: begin
            if (queued[t]) r.error = 1'b1;
            else if (w.at_head) link_head(t);
            else link_tail(t);
          end
          K_DEQ: begin
            if (!queued[t]) r.error = 1'b1;
            else unlink(t);
          end
          K_YLD: begin
            if (queued[t]) rotate_to_tail(t);
          end
          K_TICK: begin
            if (w.task_in_class) begin
              left[t] = left[t] - SLICE_W'(1);
              if (left[t] == '0) begin
                left[t] = slice_len;
                if (queued[t] && count >= 2) begin
                  rotate_to_tail(t);
                  r.resched = 1'b1;
                end
              end
            end
          end
          K_PICK: begin
            if (count != 0) r.picked_task = TASK_W'(head);
          end
          default: ;
        endcase
      end
      r.queue_empty = (count == 0);
      r.queue_count = COUNT_W'(count);
      ops_seen++;
      if (r.resched) resched_seen++;
      if (r.error) err_flags_seen++;
      if (count > peak_count) peak_count = count;
      expected_words.push_back(r);
    endfunction

    function void field_check(string name, logic [7:0] e, logic [7:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_word(rrtq_out_t got);
      rrtq_out_t e;
      if (expected_words.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      field_check("picked_task", 8'(e.picked_task), 8'(got.picked_task));
      field_check("queue_empty", 8'(e.queue_empty), 8'(got.queue_empty));
      field_check("resched", 8'(e.resched), 8'(got.resched));
      field_check("queue_count", 8'(e.queue_count), 8'(got.queue_count));
      field_check("error", 8'(e.error), 8'(got.error));
    endfunction

    // random task id, preferably one whose queued state matches
    function int some_task(bit want_queued);
      int t;
      for (int i = 0; i < 64; i++) begin
        t = $urandom_range(0, MAX_TASKS - 1);
        if (queued[t] == want_queued) return t;
      end
      return t;
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rrtq_in_t           in_item;
  logic               out_valid;
  rrtq_out_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [SLICE_W-1:0] cfg_data;

  run_queue_scoreboard sb = new();
  int                  settings_used = 0;

  round_robin_task_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) sb.check_word(out_item);
  end

  function automatic rrtq_in_t mk(logic [KIND_W-1:0] kind, int id, bit hd, bit cls);
    rrtq_in_t w;
    w.kind = kind;
    w.task_id = TASK_W'(id);
    w.at_head = hd;
    w.task_in_class = cls;
    return w;
  endfunction

  // hands one word to the unit after a random gap; start stays high when the gap is zero
  task automatic send_op(rrtq_in_t w);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start = 1'b1;
    in_item = w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_op(w);
  endtask

  // hold off until every outstanding result word has come back
  task automatic settle();
    @(negedge clk) start = 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slice(logic [SLICE_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.slice_len = v;
    settings_used++;
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // mostly sensible operations on the current queue, with some misuse mixed in
  function automatic rrtq_in_t random_op();
    rrtq_in_t w;
    int roll;
    w.at_head = 1'($urandom);
    w.task_in_class = 1'($urandom);
    w.task_id = TASK_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 30 && sb.count > 40 && $urandom_range(0, 1)) roll = 40;
    if (roll < 30) begin
      w.kind = K_ENQ;
      if ($urandom_range(0, 9) < 8) w.task_id = TASK_W'(sb.some_task(0));
    end else if (roll < 50) begin
      w.kind = K_DEQ;
      if ($urandom_range(0, 9) < 8) w.task_id = TASK_W'(sb.some_task(1));
    end else if (roll < 60) begin
      w.kind = K_YLD;
      if ($urandom_range(0, 9) < 7) w.task_id = TASK_W'(sb.some_task(1));
    end else if (roll < 90) begin
      w.kind = K_TICK;
      w.task_in_class = ($urandom_range(0, 99) < 85);
      if ($urandom_range(0, 9) < 6) w.task_id = TASK_W'(sb.head);
      else if ($urandom_range(0, 1)) w.task_id = TASK_W'(sb.some_task(1));
    end else if (roll < 98) begin
      w.kind = K_PICK;
    end else begin
      w.kind = K_PICK + KIND_W'($urandom_range(1, 3));
    end
    return w;
  endfunction

  task automatic fill_and_drain();
    int order [MAX_TASKS];
    int j;
    int tmp;
    for (int i = 0; i < MAX_TASKS; i++) order[i] = i;
    for (int i = MAX_TASKS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      send_op(mk(K_ENQ, order[i], 1'($urandom), 1'($urandom)));
    end
    send_op(mk(K_ENQ, $urandom_range(0, MAX_TASKS - 1), 1'($urandom), 1'($urandom)));
    send_op(mk(K_PICK, 0, 0, 0));
    for (int i = 0; i < 20; i++) send_op(random_op());
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (sb.queued[order[i]]) send_op(mk(K_DEQ, order[i], 1'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    logic [SLICE_W-1:0] slices [7];
    slices = '{16'd3, 16'd1, 16'd65535, 16'd2, 16'd0, 16'd7, 16'd100};
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset slice length: empty queue, bad enqueue/dequeue, ordering, odd kinds
    send_op(mk(K_PICK, 0, 0, 0));
    send_op(mk(K_DEQ, 7, 0, 0));
    send_op(mk(K_YLD, 7, 1, 1));
    send_op(mk(K_ENQ, 0, 0, 0));
    send_op(mk(K_ENQ, 63, 1, 1));
    send_op(mk(K_ENQ, 63, 0, 0));
    send_op(mk(K_ENQ, 31, 0, 1));
    send_op(mk(K_PICK, 0, 1, 1));
    send_op(mk(K_YLD, 63, 0, 0));
    send_op(mk(K_YLD, 31, 0, 0));
    send_op(mk(K_TICK, 0, 0, 0));
    send_op(mk(K_TICK, 0, 1, 1));
    send_op(mk(K_PICK + 3'd1, 42, 1, 1));
    send_op(mk(K_PICK + 3'd3, 21, 0, 0));
    send_op(mk(K_DEQ, 0, 1, 0));
    send_op(mk(K_DEQ, 31, 0, 1));
    send_op(mk(K_DEQ, 63, 0, 0));
    send_op(mk(K_PICK, 63, 0, 0));
    settle();

    // one-tick slice length: ticks on a lone task, on a task with a second one queued, and on an unqueued task
    write_slice(16'd1);
    send_op(mk(K_ENQ, 10, 0, 0));
    send_op(mk(K_TICK, 10, 0, 1));
    send_op(mk(K_ENQ, 20, 0, 0));
    send_op(mk(K_TICK, 10, 0, 1));
    send_op(mk(K_TICK, 40, 0, 1));
    send_op(mk(K_PICK, 0, 0, 0));
    settle();

    // zero slice length: ticks on an unqueued task, then both queued tasks dequeued
    write_slice(16'd0);
    send_op(mk(K_TICK, 40, 0, 1));
    send_op(mk(K_TICK, 40, 0, 1));
    send_op(mk(K_DEQ, 10, 0, 0));
    send_op(mk(K_DEQ, 20, 0, 0));
    settle();

    foreach (slices[s]) begin
      write_slice(slices[s]);
      if (slices[s] == 16'd65535) fill_and_drain();
      for (int i = 0; i < 140; i++) begin
        if ($urandom_range(0, 39) == 0) settle();
        send_op(random_op());
      end
      settle();
    end

    $display("ran %0d operations under %0d slice lengths, peak depth %0d",
             sb.ops_seen, settings_used, sb.peak_count);
    $display("saw %0d reschedules and %0d error flags", sb.resched_seen, sb.err_flags_seen);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
